### rtl/core/kli_pkg.sv
// Shared types and constants for the keyframe interpolator.
package kli_pkg;
    localparam int unsigned KEYS_DEF = 64;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_FULL  = 3'd2,
        ST_DUP   = 3'd3,
        ST_SAT   = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_SRCHW, S_DECIDE, S_SHIFTR, S_SHIFTW,
        S_QRD0, S_QRD1, S_DIV, S_MUL, S_ADD, S_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [15:0] quo;
    } t_div_rsp;
endpackage

### rtl/core/kli_if.sv
// Valid/ready channel interfaces for requests and results.
interface kli_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic signed [31:0] key_time;
    logic signed [31:0] key_value;
    logic signed [31:0] query_time;
    modport source (output valid, req_type, key_time, key_value, query_time, input ready);
    modport sink   (input valid, req_type, key_time, key_value, query_time, output ready);
endinterface

interface kli_res_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] result_value;
    logic [2:0]  status;
    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface

### rtl/core/keyframe_linear_interpolator_core.sv
// Top level: keyframe table in synchronous memory with search, insert and interpolation.
// A clear empties the table directly; an insert runs a binary search, then shifts later entries up;
// a query runs a binary search and, between two keys, a 16-step divider and a multiply.
// One request is worked at a time.
// The result register holds the output, so the next request may enter while it waits.
// Reset (synchronous, active low) empties the table; the memory itself is not cleared.
module keyframe_linear_interpolator_core #(
    parameter int unsigned KEYS = kli_pkg::KEYS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    kli_req_if.sink   i_req,
    kli_res_if.source o_res
);
    import kli_pkg::*;

    localparam int unsigned AW = $clog2(KEYS);
    localparam int unsigned CW = $clog2(KEYS + 1);

    logic [63:0] r_mem [KEYS];
    logic [63:0] r_rd;
    logic [AW-1:0] n_raddr;
    logic          n_ren;
    logic [AW-1:0] n_waddr;
    logic [63:0]   n_wdata;
    logic          n_wen;

    always_ff @(posedge i_clk) begin
        if (n_wen) r_mem[n_waddr] <= n_wdata;
        if (n_ren) r_rd <= r_mem[n_raddr];
    end

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [1:0]    r_req, n_req;
    logic signed [31:0] r_t, n_t, r_v, n_v;
    logic signed [31:0] r_v0, n_v0, r_v1, n_v1, r_t1, n_t1;
    logic signed [31:0] r_res, n_res;
    logic [2:0]    r_st, n_st;
    logic          r_ovalid, n_ovalid;
    logic signed [48:0] r_prod, n_prod;
    logic signed [31:0] r_out_v, n_out_v;
    logic [2:0]    r_out_s, n_out_s;
    t_div_req      n_dreq;
    t_div_rsp      w_drsp;
    logic signed [31:0] w_mt;
    logic [CW:0]   w_sum;
    logic signed [32:0] w_diff;
    logic signed [32:0] w_final;

    kli_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(n_dreq), .o_rsp(w_drsp));

    assign w_mt  = r_rd[63:32];
    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_diff = {r_v1[31], r_v1} - {r_v0[31], r_v0};
    assign w_final = {r_v0[31], r_v0} + r_prod[48:16];

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_res.valid  = r_ovalid;
    assign o_res.result_value = r_out_v;
    assign o_res.status = r_out_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_lo <= n_lo; r_hi <= n_hi; r_mid <= n_mid; r_ptr <= n_ptr;
        r_req <= n_req; r_t <= n_t; r_v <= n_v;
        r_t1 <= n_t1; r_v0 <= n_v0; r_v1 <= n_v1;
        r_res <= n_res; r_st <= n_st; r_prod <= n_prod;
        r_out_v <= n_out_v; r_out_s <= n_out_s;
    end

    always_comb begin
        n_state = r_state; n_count = r_count;
        n_lo = r_lo; n_hi = r_hi; n_mid = r_mid; n_ptr = r_ptr;
        n_req = r_req; n_t = r_t; n_v = r_v;
        n_t1 = r_t1; n_v0 = r_v0; n_v1 = r_v1;
        n_res = r_res; n_st = r_st; n_prod = r_prod;
        n_out_v = r_out_v; n_out_s = r_out_s;
        n_ovalid = r_ovalid && !o_res.ready;
        n_ren = 1'b0; n_raddr = '0;
        n_wen = 1'b0; n_waddr = '0; n_wdata = '0;
        n_dreq = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_req = i_req.req_type;
                    n_t = (i_req.req_type == REQ_QUERY) ? i_req.query_time : i_req.key_time;
                    n_v = i_req.key_value;
                    n_res = '0; n_st = ST_OK;
                    n_lo = '0; n_hi = r_count;
                    case (i_req.req_type)
                        REQ_CLEAR: begin n_count = '0; n_state = S_OUT; end
                        REQ_INSERT: n_state = S_SRCH;
                        REQ_QUERY: begin
                            if (r_count == '0) begin
                                n_st = ST_EMPTY; n_state = S_OUT;
                            end else n_state = S_SRCH;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            // lower bound: first index whose time >= t
            S_SRCH: begin
                if (r_lo == r_hi) n_state = S_DECIDE;
                else begin
                    n_mid = w_sum[CW:1];
                    n_raddr = w_sum[AW:1];
                    n_ren = 1'b1;
                    n_state = S_SRCHW;
                end
            end
            S_SRCHW: begin
                if (w_mt >= r_t) n_hi = r_mid;
                else n_lo = r_mid + 1'b1;
                n_state = S_SRCH;
            end
            S_DECIDE: begin
                if (r_req == REQ_INSERT) begin
                    n_ptr = r_count;
                    n_ren = 1'b1; n_raddr = r_lo[AW-1:0];
                    n_state = S_SHIFTR;
                end else begin
                    n_ren = 1'b1;
                    n_raddr = (r_lo == r_count) ? AW'(r_count - 1'b1) : r_lo[AW-1:0];
                    n_state = S_QRD0;
                end
            end
            S_SHIFTR: begin
                // r_rd holds entry at lo (valid only when lo < count)
                if (r_lo < r_count && w_mt == r_t) begin
                    n_st = ST_DUP; n_state = S_OUT;
                end else if (r_count == CW'(KEYS)) begin
                    n_st = ST_FULL; n_state = S_OUT;
                end else if (r_ptr == r_lo) begin
                    n_wen = 1'b1; n_waddr = r_lo[AW-1:0]; n_wdata = {r_t, r_v};
                    n_count = r_count + 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_ren = 1'b1; n_raddr = AW'(r_ptr - 1'b1);
                    n_state = S_SHIFTW;
                end
            end
            S_SHIFTW: begin
                n_wen = 1'b1; n_waddr = r_ptr[AW-1:0]; n_wdata = r_rd;
                n_ptr = r_ptr - 1'b1;
                n_ren = 1'b1; n_raddr = r_lo[AW-1:0];
                n_state = S_SHIFTR;
            end
            S_QRD0: begin
                n_t1 = w_mt; n_v1 = r_rd[31:0];
                if (r_lo == r_count || r_lo == '0 || w_mt == r_t) begin
                    n_res = r_rd[31:0]; n_state = S_OUT;
                end else begin
                    n_ren = 1'b1; n_raddr = AW'(r_lo - 1'b1);
                    n_state = S_QRD1;
                end
            end
            S_QRD1: begin
                n_v0 = r_rd[31:0];
                n_dreq.start = 1'b1;
                n_dreq.num = r_t - w_mt;
                n_dreq.den = r_t1 - w_mt;
                n_state = S_DIV;
            end
            S_DIV: if (w_drsp.done) n_state = S_MUL;
            S_MUL: begin
                n_prod = 49'($signed({1'b0, w_drsp.quo})) * 49'(w_diff);
                n_state = S_ADD;
            end
            S_ADD: begin
                if (w_final > 33'sd2147483647) begin
                    n_res = 32'sh7fffffff; n_st = ST_SAT;
                end else if (w_final < -33'sd2147483648) begin
                    n_res = 32'sh80000000; n_st = ST_SAT;
                end else n_res = w_final[31:0];
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid = 1'b1; n_out_v = r_res; n_out_s = r_st;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(KEYS)) else $error("key count over capacity");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> $stable(o_res.result_value))
        else $error("result changed while stalled");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == '0 || r_count == $past(r_count) + 1'b1))
        else $error("count jumped");
`endif
endmodule

### rtl/core/kli_div.sv
// Restoring divider giving a 16-bit quotient of num * 2^16 / den, num < den.
module kli_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kli_pkg::t_div_req    i_req,
    output kli_pkg::t_div_rsp    o_rsp
);
    import kli_pkg::*;

    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [15:0] r_quo;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] n_trial;

    assign n_trial = {r_rem, 1'b0} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rem  <= {1'b0, i_req.num};
                r_den  <= i_req.den;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                if (!n_trial[33]) begin
                    r_rem <= n_trial[32:0];
                    r_quo <= {r_quo[14:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[31:0], 1'b0};
                    r_quo <= {r_quo[14:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

### tb/sv/keyframe_linear_interpolator_core_tb.sv
// Testbench for the keyframe interpolator core: random and directed requests against a predictor.
`timescale 1ns / 1ps

module keyframe_linear_interpolator_core_tb;
    import kli_pkg::*;

    localparam int unsigned NKEYS    = KEYS_DEF;
    localparam int          WD_LIMIT = 20000;
    localparam int          N_RANDOM = 930;

    typedef struct packed {
        t_req        kind;
        logic [31:0] ktime;
        logic [31:0] kvalue;
        logic [31:0] qtime;
    } t_request;

    typedef struct packed {
        logic [31:0] value;
        t_status     status;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    kli_req_if req_ch ();
    kli_res_if res_ch ();

    keyframe_linear_interpolator_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    // predictor copy of the keyframe table
    logic signed [31:0] tbl_time [NKEYS];
    logic signed [31:0] tbl_value[NKEYS];
    int unsigned        tbl_count;

    t_request pending_reqs[$];
    t_answer  expected_answers[$];

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_sender;
    bit req_taken;
    int mismatches;
    int results_seen;
    int watchdog;
    int n_queries;
    int n_interp;
    int n_full;
    int n_dup;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned lower_pos(logic signed [31:0] t);
        int unsigned i;
        for (i = 0; i < tbl_count; i++)
            if (tbl_time[i] >= t) return i;
        return tbl_count;
    endfunction

    function automatic t_answer evaluate_request(t_request r);
        t_answer a;
        int unsigned pos;
        int unsigned i;
        longint t0, t1, v0, v1, num, den, frac, prod, dlt, res;
        a.value  = '0;
        a.status = ST_OK;
        case (r.kind)
            REQ_CLEAR: begin
                tbl_count = 0;
            end
            REQ_INSERT: begin
                pos = lower_pos(r.ktime);
                if (pos < tbl_count && tbl_time[pos] == $signed(r.ktime)) begin
                    a.status = ST_DUP;
                    n_dup++;
                end else if (tbl_count >= NKEYS) begin
                    a.status = ST_FULL;
                    n_full++;
                end else begin
                    for (i = tbl_count; i > pos; i--) begin
                        tbl_time[i]  = tbl_time[i-1];
                        tbl_value[i] = tbl_value[i-1];
                    end
                    tbl_time[pos]  = r.ktime;
                    tbl_value[pos] = r.kvalue;
                    tbl_count++;
                end
            end
            REQ_QUERY: begin
                n_queries++;
                if (tbl_count == 0) begin
                    a.status = ST_EMPTY;
                end else begin
                    pos = lower_pos(r.qtime);
                    if (pos >= tbl_count) begin
                        a.value = tbl_value[tbl_count-1];
                    end else if (pos == 0 || tbl_time[pos] == $signed(r.qtime)) begin
                        a.value = tbl_value[pos];
                    end else begin
                        n_interp++;
                        t0 = tbl_time[pos-1];
                        t1 = tbl_time[pos];
                        v0 = tbl_value[pos-1];
                        v1 = tbl_value[pos];
                        num = ($signed(r.qtime) - t0) <<< 16;
                        den = t1 - t0;
                        frac = num / den;
                        if (frac > 65535) frac = 65535;
                        prod = frac * (v1 - v0);
                        dlt = prod >>> 16;
                        res = v0 + dlt;
                        if (res > 64'sd2147483647) begin
                            res = 64'sd2147483647;
                            a.status = ST_SAT;
                        end
                        if (res < -64'sd2147483648) begin
                            res = -64'sd2147483648;
                            a.status = ST_SAT;
                        end
                        a.value = res[31:0];
                    end
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic t_request make_req(t_req k, logic [31:0] kt, logic [31:0] kv,
                                          logic [31:0] qt);
        t_request r;
        r.kind   = k;
        r.ktime  = kt;
        r.kvalue = kv;
        r.qtime  = qt;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 3)
                                                 : 32'h80000000 + $urandom_range(0, 3);
        endcase
    endfunction

    task automatic queue_req(t_request r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // driver: present the head of the queue, drop it once the transaction completes
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_taken = 1'b0;
        end else if (req_ch.valid && !req_taken) begin
            // hold
        end else begin
            if (req_taken) void'(pending_reqs.pop_front());
            req_taken = 1'b0;
            if (pending_reqs.size() != 0 && !hold_sender &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                req_ch.valid      <= 1'b1;
                req_ch.req_type   <= pending_reqs[0].kind;
                req_ch.key_time   <= pending_reqs[0].ktime;
                req_ch.key_value  <= pending_reqs[0].kvalue;
                req_ch.query_time <= pending_reqs[0].qtime;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
        res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor: predict at request acceptance, check at result acceptance
    always @(posedge i_clk) begin
        t_answer exp_a;
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                watchdog = 0;
            else
                watchdog = watchdog + 1;
            if (req_ch.valid && req_ch.ready) begin
                expected_answers.insert(expected_answers.size(), evaluate_request(make_req(
                    t_req'(req_ch.req_type), req_ch.key_time, req_ch.key_value,
                    req_ch.query_time)));
                req_taken = 1'b1;
            end
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (expected_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result value=%h status=%0d",
                                 res_ch.result_value, res_ch.status);
                end else begin
                    exp_a = expected_answers.pop_front();
                    if (res_ch.result_value !== exp_a.value ||
                        res_ch.status !== exp_a.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected %h/%0d, got %h/%0d",
                                     results_seen, exp_a.value, exp_a.status,
                                     res_ch.result_value, res_ch.status);
                    end
                end
            end
            if (watchdog >= WD_LIMIT) begin
                $display("watchdog expired with %0d results outstanding",
                         expected_answers.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task automatic drain_all();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_answers.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic add_random_phase(int n);
        int i, j, nk;
        logic [31:0] base;
        for (i = 0; i < n; ) begin
            case ($urandom_range(0, 9))
                0: begin
                    queue_req(make_req(REQ_CLEAR, rand_word(), rand_word(), rand_word()));
                    i++;
                end
                1: begin
                    // fill past capacity with ascending times
                    base = $urandom;
                    for (j = 0; j < NKEYS + 3; j++)
                        queue_req(make_req(REQ_INSERT, base + j * 7, rand_word(),
                                           rand_word()));
                    i += NKEYS + 3;
                end
                2: begin
                    queue_req(make_req(t_req'($urandom_range(0, 3)), $urandom,
                                       $urandom, $urandom));
                    i++;
                end
                default: begin
                    // small curve then queries across and around it
                    queue_req(make_req(REQ_CLEAR, 0, 0, 0));
                    nk = $urandom_range(1, 6);
                    base = rand_word();
                    for (j = 0; j < nk; j++)
                        queue_req(make_req(REQ_INSERT,
                            $urandom_range(0, 1) ? rand_word() : base + $urandom_range(0, 5000),
                            rand_word(), rand_word()));
                    for (j = 0; j < 6; j++)
                        queue_req(make_req(REQ_QUERY, rand_word(), rand_word(),
                            $urandom_range(0, 2) != 0 ? base + $urandom_range(0, 5200)
                                                      : rand_word()));
                    i += nk + 7;
                end
            endcase
        end
    endtask

    initial begin
        i_clk = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_CLEAR;
        req_ch.key_time   = '0;
        req_ch.key_value  = '0;
        req_ch.query_time = '0;
        res_ch.ready      = 1'b0;
        i_rst_n = 1'b0;
        tbl_count = 0;
        mismatches = 0;
        results_seen = 0;
        watchdog = 0;
        n_queries = 0;
        n_interp = 0;
        n_full = 0;
        n_dup = 0;
        hold_sender = 1'b0;
        req_taken = 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 69;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty query, extremes, duplicates, exact hits, interpolation, idle code
        queue_req(make_req(REQ_QUERY, 0, 0, 32'h12345678));
        queue_req(make_req(REQ_INSERT, 32'h80000000, 32'h7FFFFFFF, 0));
        queue_req(make_req(REQ_INSERT, 32'h7FFFFFFF, 32'h80000000, 0));
        queue_req(make_req(REQ_INSERT, 32'h7FFFFFFF, 32'h00000001, 0));
        queue_req(make_req(REQ_QUERY, 0, 0, 32'h80000000));
        queue_req(make_req(REQ_QUERY, 0, 0, 32'h7FFFFFFF));
        queue_req(make_req(REQ_QUERY, 0, 0, 32'h00000000));
        queue_req(make_req(REQ_QUERY, 0, 0, 32'h7FFFFFFE));
        queue_req(make_req(REQ_QUERY, 0, 0, 32'h80000001));
        queue_req(make_req(REQ_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
        queue_req(make_req(REQ_CLEAR, 0, 0, 0));
        queue_req(make_req(REQ_QUERY, 0, 0, 0));
        queue_req(make_req(REQ_INSERT, 32'h00010000, 32'h00000000, 0));
        queue_req(make_req(REQ_INSERT, 32'h00030000, 32'h00020000, 0));
        queue_req(make_req(REQ_INSERT, 32'h00020000, 32'hFFFF0000, 0));
        queue_req(make_req(REQ_QUERY, 0, 0, 32'h00000000));
        queue_req(make_req(REQ_QUERY, 0, 0, 32'h00018000));
        queue_req(make_req(REQ_QUERY, 0, 0, 32'h00020000));
        queue_req(make_req(REQ_QUERY, 0, 0, 32'h00025555));
        queue_req(make_req(REQ_QUERY, 0, 0, 32'h00040000));
        queue_req(make_req(REQ_INSERT, 32'h00020000, 32'h5, 0));
        queue_req(make_req(REQ_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
        add_random_phase(300);
        drain_all();

        // pause the sender, let every outstanding result come back, then leave the core idle
        hold_sender = 1'b1;
        drain_all();
        repeat (60) @(posedge i_clk);
        hold_sender = 1'b0;

        send_idle_pct = 69;
        recv_idle_pct = 18;
        add_random_phase(310);
        drain_all();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_phase(N_RANDOM - 610);
        drain_all();
        repeat (200) @(posedge i_clk);

        $display("covered %0d results: %0d queries (%0d interpolated), %0d full, %0d duplicate",
                 results_seen, n_queries, n_interp, n_full, n_dup);
        if (mismatches == 0 && expected_answers.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
